FILE: src/cft_pkg.sv
// Package for the CSV field tokenizer: types, constants and character classes.
// Used by every module of the block; depends on nothing.
package cft_pkg;

  localparam int unsigned ByteW     = 8;
  localparam int unsigned ValueW    = 32;
  localparam int unsigned AccW      = ValueW + 4;
  localparam int unsigned AddrW     = 4;
  localparam int unsigned DataW     = 32;
  localparam int unsigned FifoDepth = 4;
  localparam int unsigned FifoPtrW  = 2;
  localparam int unsigned FifoCntW  = 3;

  localparam logic [ByteW-1:0] FieldDelimRst = 8'd44;
  localparam logic [ByteW-1:0] QuoteOpenRst  = 8'd34;
  localparam logic [ByteW-1:0] QuoteCloseRst = 8'd34;

  // Register indexes (byte address divided by four).
  typedef enum logic [1:0] {
    REG_FIELD_DELIM = 2'd0,
    REG_QUOTE_OPEN  = 2'd1,
    REG_QUOTE_CLOSE = 2'd2
  } reg_idx_e;

  typedef enum logic [2:0] {
    PH_PRE    = 3'd0,
    PH_WORD   = 3'd1,
    PH_NUMBER = 3'd2,
    PH_TEXT   = 3'd3,
    PH_POST   = 3'd4
  } phase_e;

  typedef enum logic [2:0] {
    K_WORD_BYTE = 3'd0,
    K_TEXT_BYTE = 3'd1,
    K_NUM_DONE  = 3'd2,
    K_WORD_END  = 3'd3,
    K_TEXT_END  = 3'd4,
    K_EMPTY     = 3'd5,
    K_LINE_DONE = 3'd6
  } kind_e;

  typedef struct packed {
    logic [ByteW-1:0] field_delim;
    logic [ByteW-1:0] quote_open;
    logic [ByteW-1:0] quote_close;
  } cfg_t;

  typedef struct packed {
    kind_e             kind;
    logic [ByteW-1:0]  data;
    logic [ValueW-1:0] value;
    logic              ovf;
    logic              last;
  } result_t;

  // Whitespace is tab, line feed, vertical tab, form feed, carriage return and space.
  function automatic logic is_space(input logic [ByteW-1:0] c);
    return ((c >= 8'd9) && (c <= 8'd13)) || (c == 8'd32);
  endfunction

  function automatic logic is_digit(input logic [ByteW-1:0] c);
    return (c >= 8'd48) && (c <= 8'd57);
  endfunction

endpackage

FILE: src/cft_regs.sv
// Configuration registers of the CSV field tokenizer behind an APB-style port.
// Depends on cft_pkg.
module cft_regs
  import cft_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [AddrW-1:0] paddr,
  input  logic [DataW-1:0] pwdata,
  output logic [DataW-1:0] prdata,
  output logic             pready,
  output cfg_t             cfg_o
);

  cfg_t     cfg_q;
  cfg_t     cfg_d;
  reg_idx_e idx;
  logic     wr_en;

  assign idx    = reg_idx_e'(paddr[AddrW-1:2]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  // Write decode.
  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (idx)
        REG_FIELD_DELIM: cfg_d.field_delim = pwdata[ByteW-1:0];
        REG_QUOTE_OPEN:  cfg_d.quote_open  = pwdata[ByteW-1:0];
        REG_QUOTE_CLOSE: cfg_d.quote_close = pwdata[ByteW-1:0];
        default:         cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.field_delim <= FieldDelimRst;
      cfg_q.quote_open  <= QuoteOpenRst;
      cfg_q.quote_close <= QuoteCloseRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // Read decode.
  always_comb begin
    unique case (idx)
      REG_FIELD_DELIM: prdata = {{(DataW-ByteW){1'b0}}, cfg_q.field_delim};
      REG_QUOTE_OPEN:  prdata = {{(DataW-ByteW){1'b0}}, cfg_q.quote_open};
      REG_QUOTE_CLOSE: prdata = {{(DataW-ByteW){1'b0}}, cfg_q.quote_close};
      default:         prdata = '0;
    endcase
  end

endmodule

FILE: src/cft_parser.sv
// Field parser of the CSV field tokenizer: phase, number accumulator and the
// results one word produces. Depends on cft_pkg.
module cft_parser
  import cft_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  cfg_t             cfg_i,
  input  logic             step_i,
  input  logic [ByteW-1:0] in_byte_i,
  input  logic             line_end_i,
  output logic [1:0]       res_cnt_o,
  output result_t          res0_o,
  output result_t          res1_o
);

  phase_e            phase_q, phase_d;
  logic [ValueW-1:0] acc_q, acc_d;
  logic              ovf_q, ovf_d;

  logic              c_delim, c_space, c_digit, c_qopen, c_qclose;
  logic [AccW-1:0]   acc_next;
  result_t           num_res;

  assign c_delim  = (in_byte_i == cfg_i.field_delim);
  assign c_space  = is_space(in_byte_i);
  assign c_digit  = is_digit(in_byte_i);
  assign c_qopen  = (in_byte_i == cfg_i.quote_open);
  assign c_qclose = (in_byte_i == cfg_i.quote_close);

  // acc * 10 + digit, as two shifted adds; the digit value is the low nibble.
  assign acc_next = {1'b0, acc_q, 3'b000} + {3'b000, acc_q, 1'b0}
                  + {{(AccW-4){1'b0}}, in_byte_i[3:0]};

  // Completed number result.
  always_comb begin
    num_res       = '0;
    num_res.kind  = K_NUM_DONE;
    num_res.value = ovf_q ? '0 : acc_q;
    num_res.ovf   = ovf_q;
  end

  // Next state.
  always_comb begin
    phase_d = phase_q;
    acc_d   = acc_q;
    ovf_d   = ovf_q;
    if (line_end_i) begin
      phase_d = PH_PRE;
      acc_d   = '0;
      ovf_d   = 1'b0;
    end else begin
      unique case (phase_q)
        PH_WORD: begin
          if (c_delim)      phase_d = PH_PRE;
          else if (c_space) phase_d = PH_POST;
        end
        PH_NUMBER: begin
          if (c_digit) begin
            if (acc_next[AccW-1:ValueW] != '0) begin
              ovf_d = 1'b1;
              acc_d = '0;
            end else if (!ovf_q) begin
              acc_d = acc_next[ValueW-1:0];
            end
          end else begin
            acc_d   = '0;
            ovf_d   = 1'b0;
            phase_d = c_delim ? PH_PRE : PH_POST;
          end
        end
        PH_TEXT: begin
          if (c_qclose) phase_d = PH_POST;
        end
        PH_POST: begin
          if (c_delim) phase_d = PH_PRE;
        end
        default: begin
          if (c_delim || c_space) begin
            phase_d = PH_PRE;
          end else if (c_digit) begin
            acc_d   = {{(ValueW-4){1'b0}}, in_byte_i[3:0]};
            ovf_d   = 1'b0;
            phase_d = PH_NUMBER;
          end else if (c_qopen) begin
            phase_d = PH_TEXT;
          end else begin
            phase_d = PH_WORD;
          end
        end
      endcase
    end
  end

  // Results for the current word; the final one carries last.
  always_comb begin
    res_cnt_o = 2'd0;
    res0_o    = '0;
    res1_o    = '0;
    if (line_end_i) begin
      res1_o.kind = K_LINE_DONE;
      res1_o.last = 1'b1;
      res_cnt_o   = 2'd2;
      unique case (phase_q)
        PH_WORD:   res0_o.kind = K_WORD_END;
        PH_NUMBER: res0_o = num_res;
        PH_TEXT:   res0_o.kind = K_TEXT_END;
        default: begin
          res0_o    = res1_o;
          res_cnt_o = 2'd1;
        end
      endcase
    end else begin
      unique case (phase_q)
        PH_WORD: begin
          res_cnt_o = 2'd1;
          if (c_delim || c_space) begin
            res0_o.kind = K_WORD_END;
          end else begin
            res0_o.kind = K_WORD_BYTE;
            res0_o.data = in_byte_i;
          end
        end
        PH_NUMBER: begin
          if (!c_digit) begin
            res0_o    = num_res;
            res_cnt_o = 2'd1;
          end
        end
        PH_TEXT: begin
          res_cnt_o = 2'd1;
          if (c_qclose) begin
            res0_o.kind = K_TEXT_END;
          end else begin
            res0_o.kind = K_TEXT_BYTE;
            res0_o.data = in_byte_i;
          end
        end
        PH_POST: res_cnt_o = 2'd0;
        default: begin
          if (c_delim) begin
            res0_o.kind = K_EMPTY;
            res_cnt_o   = 2'd1;
          end else if (!c_space && !c_digit && !c_qopen) begin
            res0_o.kind = K_WORD_BYTE;
            res0_o.data = in_byte_i;
            res_cnt_o   = 2'd1;
          end
        end
      endcase
      if (res_cnt_o != 2'd0) res0_o.last = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_PRE;
      acc_q   <= '0;
      ovf_q   <= 1'b0;
    end else if (step_i) begin
      phase_q <= phase_d;
      acc_q   <= acc_d;
      ovf_q   <= ovf_d;
    end
  end

endmodule

FILE: src/cft_out_fifo.sv
// Result queue of the CSV field tokenizer: takes up to two results per cycle
// and hands out one per cycle while ready_i is high. Depends on cft_pkg.
module cft_out_fifo
  import cft_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  input  logic [1:0] push_cnt_i,
  input  result_t    push0_i,
  input  result_t    push1_i,
  output logic       space_o,
  output logic       valid_o,
  input  logic       ready_i,
  output result_t    data_o
);

  result_t              mem_q [FifoDepth];
  logic [FifoPtrW-1:0]  wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d, wr_ptr_nx;
  logic [FifoCntW-1:0]  cnt_q, cnt_d, n_push;
  logic                 pop;

  assign n_push    = push_i ? {1'b0, push_cnt_i} : '0;
  assign pop       = valid_o && ready_i;
  assign valid_o   = (cnt_q != '0);
  assign data_o    = mem_q[rd_ptr_q];
  // Room for the two results a single word can cause.
  assign space_o   = (cnt_q <= FifoCntW'(FifoDepth - 2));
  assign wr_ptr_nx = wr_ptr_q + 1'b1;

  assign wr_ptr_d = wr_ptr_q + n_push[FifoPtrW-1:0];
  assign rd_ptr_d = rd_ptr_q + {{(FifoPtrW-1){1'b0}}, pop};
  assign cnt_d    = cnt_q + n_push - {{(FifoCntW-1){1'b0}}, pop};

  // Storage.
  always_ff @(posedge clk_i) begin
    if (n_push != '0) mem_q[wr_ptr_q] <= push0_i;
    if (n_push == FifoCntW'(2)) mem_q[wr_ptr_nx] <= push1_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

endmodule

FILE: src/csv_field_tokenizer.sv
// The tokenizer takes one byte of a CSV line per word (or an end-of-line mark)
// and emits field results: word and quoted-text bytes as they arrive, field ends,
// empty fields, finished decimal numbers with an overflow flag, and line done.
// A word is parsed in the cycle it is accepted and a new word may be accepted
// every cycle; results leave through a four-entry result queue, one per cycle
// while out_ready_i is high, so an end of line that closes an open field gives
// two results. Input stalls only while the queue cannot take two more results.
// Depends on cft_pkg, cft_regs, cft_parser and cft_out_fifo.
module csv_field_tokenizer
  import cft_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [AddrW-1:0]  paddr,
  input  logic [DataW-1:0]  pwdata,
  output logic [DataW-1:0]  prdata,
  output logic              pready,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [ByteW-1:0]  in_byte_i,
  input  logic              line_end_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [2:0]        kind_o,
  output logic [ByteW-1:0]  out_byte_o,
  output logic [ValueW-1:0] number_value_o,
  output logic              number_overflow_o,
  output logic              last_o
);

  cfg_t       cfg;
  logic       step;
  logic [1:0] res_cnt;
  result_t    res0, res1, res_out;

  assign step = in_valid_i && in_ready_o;

  cft_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  cft_parser u_parser (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg),
    .step_i     (step),
    .in_byte_i  (in_byte_i),
    .line_end_i (line_end_i),
    .res_cnt_o  (res_cnt),
    .res0_o     (res0),
    .res1_o     (res1)
  );

  cft_out_fifo u_out_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (step),
    .push_cnt_i (res_cnt),
    .push0_i    (res0),
    .push1_i    (res1),
    .space_o    (in_ready_o),
    .valid_o    (out_valid_o),
    .ready_i    (out_ready_i),
    .data_o     (res_out)
  );

  assign kind_o            = res_out.kind;
  assign out_byte_o        = res_out.data;
  assign number_value_o    = res_out.value;
  assign number_overflow_o = res_out.ovf;
  assign last_o            = res_out.last;

`ifndef NO_ASSERTIONS
  // Line done is always the final result of its word.
  a_line_done_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (kind_o == K_LINE_DONE) |-> last_o)
    else $error("line done without last");

  // Only a finished number carries a value or an overflow flag.
  a_value_only_number: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (kind_o != K_NUM_DONE) |-> (number_value_o == '0) && !number_overflow_o)
    else $error("value on a non-number result");

  // Input back-pressure only comes from queued results.
  a_stall_has_results: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o)
    else $error("input stalled with an empty result queue");

  // An overflowed number reports zero.
  a_ovf_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && number_overflow_o |-> (number_value_o == '0))
    else $error("overflowed number with nonzero value");
`endif

endmodule

FILE: sim/csv_field_tokenizer_tb.sv
// Self-checking testbench for csv_field_tokenizer: drives lines of bytes through the
// valid/ready input, predicts every field result and checks the output stream.
// Depends on cft_pkg and the csv_field_tokenizer RTL.
module csv_field_tokenizer_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import cft_pkg::*;

  // One input word: a line byte or an end-of-line mark.
  typedef struct packed {
    logic [ByteW-1:0] ch;
    logic             eol;
  } line_item_t;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [AddrW-1:0]  paddr = '0;
  logic [DataW-1:0]  pwdata = '0;
  logic [DataW-1:0]  prdata;
  logic              pready;
  logic              in_valid_i = 1'b0;
  logic              in_ready_o;
  logic [ByteW-1:0]  in_byte_i = '0;
  logic              line_end_i = 1'b0;
  logic              out_valid_o;
  logic              out_ready_i = 1'b0;
  logic [2:0]        kind_o;
  logic [ByteW-1:0]  out_byte_o;
  logic [ValueW-1:0] number_value_o;
  logic              number_overflow_o;
  logic              last_o;

  csv_field_tokenizer u_top (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .prdata            (prdata),
    .pready            (pready),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .in_byte_i         (in_byte_i),
    .line_end_i        (line_end_i),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .kind_o            (kind_o),
    .out_byte_o        (out_byte_o),
    .number_value_o    (number_value_o),
    .number_overflow_o (number_overflow_o),
    .last_o            (last_o)
  );

  // Tokenizer shadow state and register copy.
  cfg_t              tok_cfg = '{field_delim: FieldDelimRst, quote_open: QuoteOpenRst,
                                 quote_close: QuoteCloseRst};
  phase_e            tok_phase = PH_PRE;
  logic [ValueW-1:0] tok_acc = '0;
  logic              tok_ovf = 1'b0;

  line_item_t pending_q[$];
  result_t    expected_q[$];
  line_item_t nxt;
  result_t    want;

  int unsigned send_idle_pct = 0;
  int unsigned stall_pct = 0;
  int unsigned err_count = 0;
  int unsigned words_sent = 0;
  int unsigned results_seen = 0;
  int unsigned lines_built = 0;
  int unsigned phase_items = 0;

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  initial begin
    #400000;
    $display("[FAIL] regression broken");
    $finish;
  end

  // Character classes of the line format.
  function automatic logic is_blank(input logic [ByteW-1:0] c);
    return (c inside {[8'd9:8'd13]}) || (c == 8'd32);
  endfunction

  function automatic logic is_decimal(input logic [ByteW-1:0] c);
    return (c >= 8'd48) && (c <= 8'd57);
  endfunction

  function automatic result_t make_result(input kind_e k, input logic [ByteW-1:0] b,
                                          input logic [ValueW-1:0] v, input logic o);
    result_t r;
    r.kind = k;
    r.data = b;
    r.value = v;
    r.ovf = o;
    r.last = 1'b0;
    return r;
  endfunction

  // Emits the finished number and clears the accumulator.
  function automatic result_t close_number();
    result_t r;
    r = make_result(K_NUM_DONE, '0, tok_ovf ? '0 : tok_acc, tok_ovf);
    tok_acc = '0;
    tok_ovf = 1'b0;
    return r;
  endfunction

  // Advances the shadow tokenizer by one accepted word and queues its results.
  task automatic predict_tokens(input logic [ByteW-1:0] c, input logic eol);
    result_t     step_q[$];
    logic [35:0] wide;
    if (eol) begin
      case (tok_phase)
        PH_WORD:   step_q.push_back(make_result(K_WORD_END, '0, '0, 1'b0));
        PH_NUMBER: step_q.push_back(close_number());
        PH_TEXT:   step_q.push_back(make_result(K_TEXT_END, '0, '0, 1'b0));
        default: ;
      endcase
      step_q.push_back(make_result(K_LINE_DONE, '0, '0, 1'b0));
      tok_phase = PH_PRE;
      tok_acc = '0;
      tok_ovf = 1'b0;
    end else begin
      case (tok_phase)
        PH_WORD: begin
          if (c == tok_cfg.field_delim) begin
            step_q.push_back(make_result(K_WORD_END, '0, '0, 1'b0));
            tok_phase = PH_PRE;
          end else if (is_blank(c)) begin
            step_q.push_back(make_result(K_WORD_END, '0, '0, 1'b0));
            tok_phase = PH_POST;
          end else begin
            step_q.push_back(make_result(K_WORD_BYTE, c, '0, 1'b0));
          end
        end
        PH_NUMBER: begin
          if (is_decimal(c)) begin
            wide = 36'(tok_acc) * 36'd10 + (36'(c) - 36'd48);
            if (wide > 36'hFFFF_FFFF) begin
              tok_ovf = 1'b1;
              tok_acc = '0;
            end else if (!tok_ovf) begin
              tok_acc = wide[31:0];
            end
          end else begin
            step_q.push_back(close_number());
            tok_phase = (c == tok_cfg.field_delim) ? PH_PRE : PH_POST;
          end
        end
        PH_TEXT: begin
          if (c == tok_cfg.quote_close) begin
            step_q.push_back(make_result(K_TEXT_END, '0, '0, 1'b0));
            tok_phase = PH_POST;
          end else begin
            step_q.push_back(make_result(K_TEXT_BYTE, c, '0, 1'b0));
          end
        end
        PH_POST: begin
          if (c == tok_cfg.field_delim) tok_phase = PH_PRE;
        end
        default: begin
          // Before a field the delimiter wins over every other class.
          if (c == tok_cfg.field_delim) begin
            step_q.push_back(make_result(K_EMPTY, '0, '0, 1'b0));
            tok_phase = PH_PRE;
          end else if (is_blank(c)) begin
            tok_phase = PH_PRE;
          end else if (is_decimal(c)) begin
            tok_acc = 32'(c) - 32'd48;
            tok_ovf = 1'b0;
            tok_phase = PH_NUMBER;
          end else if (c == tok_cfg.quote_open) begin
            tok_phase = PH_TEXT;
          end else begin
            step_q.push_back(make_result(K_WORD_BYTE, c, '0, 1'b0));
            tok_phase = PH_WORD;
          end
        end
      endcase
    end
    if (step_q.size() > 0) step_q[step_q.size()-1].last = 1'b1;
    foreach (step_q[i]) expected_q.push_back(step_q[i]);
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] exp_val);
    if (err_count < 20)
      $display("mismatch at result %0d: %s is 0x%0h, expected 0x%0h",
               results_seen, what, got, exp_val);
    err_count++;
  endtask

  // Input driver: the prediction is made at the edge where a word is accepted.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        predict_tokens(in_byte_i, line_end_i);
        words_sent++;
      end
      if (!in_valid_i || in_ready_o) begin
        if (pending_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          nxt = pending_q.pop_front();
          in_valid_i <= 1'b1;
          in_byte_i  <= nxt.ch;
          line_end_i <= nxt.eol;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Output monitor: compares each accepted result with the oldest expectation.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        results_seen++;
        if (expected_q.size() == 0) begin
          report_mismatch("unexpected result, kind", 32'(kind_o), '0);
        end else begin
          want = expected_q.pop_front();
          if (kind_o !== want.kind) report_mismatch("kind", 32'(kind_o), 32'(want.kind));
          if (out_byte_o !== want.data)
            report_mismatch("out_byte", 32'(out_byte_o), 32'(want.data));
          if (number_value_o !== want.value)
            report_mismatch("number_value", number_value_o, want.value);
          if (number_overflow_o !== want.ovf)
            report_mismatch("number_overflow", 32'(number_overflow_o), 32'(want.ovf));
          if (last_o !== want.last) report_mismatch("last", 32'(last_o), 32'(want.last));
        end
      end
      out_ready_i <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  // Stimulus helpers.
  task automatic push_char(input logic [ByteW-1:0] c);
    pending_q.push_back('{ch: c, eol: 1'b0});
    phase_items++;
  endtask

  task automatic push_eol();
    pending_q.push_back('{ch: 8'($urandom), eol: 1'b1});
    phase_items++;
    lines_built++;
  endtask

  task automatic push_str(input string s);
    for (int i = 0; i < s.len(); i++) push_char(s[i]);
  endtask

  task automatic push_decimal(input logic [63:0] v);
    logic [ByteW-1:0] digits[$];
    do begin
      digits.push_front(8'd48 + 8'(v % 10));
      v = v / 10;
    end while (v != 0);
    // Now and then the number gets a leading zero.
    if ($urandom_range(0, 5) == 0) digits.push_front(8'd48);
    foreach (digits[i]) push_char(digits[i]);
  endtask

  function automatic logic [ByteW-1:0] pick_blank();
    logic [ByteW-1:0] c;
    c = 8'd32;
    while (c == tok_cfg.field_delim) begin
      c = ($urandom_range(0, 5) == 5) ? 8'd32 : 8'(9 + $urandom_range(0, 4));
    end
    return c;
  endfunction

  // A word byte: no delimiter or blank; the first one also no digit or opening quote.
  function automatic logic [ByteW-1:0] pick_word_char(input logic first);
    logic [ByteW-1:0] c;
    c = 8'($urandom);
    while (c == tok_cfg.field_delim || is_blank(c) ||
           (first && (is_decimal(c) || c == tok_cfg.quote_open)))
      c = 8'($urandom);
    return c;
  endfunction

  function automatic logic [ByteW-1:0] pick_other_than(input logic [ByteW-1:0] avoid);
    logic [ByteW-1:0] c;
    c = 8'($urandom);
    while (c == avoid) c = 8'($urandom);
    return c;
  endfunction

  task automatic gen_number();
    case ($urandom_range(0, 5))
      0: push_decimal(64'd4294967295);
      1: push_decimal(64'd4294967296);
      2: push_decimal(64'($urandom_range(0, 99)));
      5: repeat ($urandom_range(11, 14)) push_char(8'd48 + 8'($urandom_range(0, 9)));
      default: push_decimal(64'($urandom));
    endcase
  endtask

  // One field: optional leading blanks, a body of some kind, optional trailing junk.
  task automatic gen_field();
    int unsigned sel;
    repeat ($urandom_range(0, 2)) push_char(pick_blank());
    sel = $urandom_range(0, 99);
    if (sel < 12) begin
      // empty field
    end else if (sel < 40) begin
      push_char(pick_word_char(1'b1));
      repeat ($urandom_range(0, 5)) push_char(pick_word_char(1'b0));
    end else if (sel < 68) begin
      gen_number();
    end else if (sel < 92) begin
      push_char(tok_cfg.quote_open);
      repeat ($urandom_range(0, 6)) push_char(pick_other_than(tok_cfg.quote_close));
      if ($urandom_range(0, 7) != 0) push_char(tok_cfg.quote_close);
    end else begin
      repeat ($urandom_range(1, 6)) push_char(8'($urandom));
    end
    if ($urandom_range(0, 3) == 0) begin
      push_char(pick_blank());
      repeat ($urandom_range(0, 3)) push_char(pick_other_than(tok_cfg.field_delim));
    end
  endtask

  task automatic gen_line();
    int unsigned n_fields;
    n_fields = $urandom_range(1, 5);
    for (int i = 0; i < n_fields; i++) begin
      if (i > 0) push_char(tok_cfg.field_delim);
      gen_field();
    end
    push_eol();
  endtask

  // Register write: setup phase, then access phase.
  task automatic write_reg(input reg_idx_e idx, input logic [ByteW-1:0] val);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= {24'($urandom), val};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_FIELD_DELIM: tok_cfg.field_delim = val;
      REG_QUOTE_OPEN:  tok_cfg.quote_open = val;
      default:         tok_cfg.quote_close = val;
    endcase
  endtask

  // Waits until every word is sent and every result has arrived, then a short tail.
  task automatic wait_drained();
    @(negedge clk_i);
    while (pending_q.size() != 0 || in_valid_i || expected_q.size() != 0) @(negedge clk_i);
    repeat (8) @(negedge clk_i);
  endtask

  // Main sequence: register settings from reset values through the extremes.
  initial begin
    logic [ByteW-1:0] delim_set[5];
    logic [ByteW-1:0] open_set[5];
    logic [ByteW-1:0] close_set[5];
    int unsigned      idle_set[5];
    int unsigned      stall_set[5];
    delim_set = '{8'd44, 8'hFF, 8'h00, 8'd9,  8'd59};
    open_set  = '{8'd34, 8'h00, 8'hFF, 8'd91, 8'd39};
    close_set = '{8'd34, 8'd39, 8'hFF, 8'd93, 8'd39};
    idle_set  = '{0, 76, 0, 19, 76};
    stall_set = '{0, 0, 76, 19, 76};
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    for (int ph = 0; ph < 5; ph++) begin
      if (ph > 0) begin
        write_reg(REG_FIELD_DELIM, delim_set[ph]);
        write_reg(REG_QUOTE_OPEN, open_set[ph]);
        write_reg(REG_QUOTE_CLOSE, close_set[ph]);
      end
      send_idle_pct = idle_set[ph];
      stall_pct = stall_set[ph];
      phase_items = 0;
      @(negedge clk_i);
      if (ph == 0) begin
        // Empty field, word ended by delimiter, word ended by blank with junk after.
        push_str(",");
        push_str(" a,b c,");
        // Number ended by a non-delimiter, then a delimiter inside quoted text.
        push_str("99x,");
        push_str("\"a,\"z");
        push_eol();
        // Empty quotes, unclosed quote at end of line.
        push_str("\"\"");
        push_eol();
        push_str("\"q");
        push_eol();
        // Extreme word bytes and a number left open at end of line.
        push_char(8'hFF);
        push_char(8'h00);
        push_eol();
        push_str("7");
        push_eol();
        push_eol();
      end
      while (phase_items < 120) gen_line();
      wait_drained();
    end
    $display("sent %0d words in %0d lines under 5 register settings and five idle mixes",
             words_sent, lines_built);
    $display("checked %0d results, %0d mismatches", results_seen, err_count);
    if (err_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

FILE: sim.f
src/cft_pkg.sv
src/cft_regs.sv
src/cft_parser.sv
src/cft_out_fifo.sv
src/csv_field_tokenizer.sv
sim/csv_field_tokenizer_tb.sv
